[hdl/cawf_pkg.sv]
// Shared types and codes for the conditional ALU with flags.
package cawf_pkg;

	// Operation codes: data processing in opcode order, then multiply
	localparam logic [4:0] OP_AND = 5'd0;
	localparam logic [4:0] OP_EOR = 5'd1;
	localparam logic [4:0] OP_SUB = 5'd2;
	localparam logic [4:0] OP_RSB = 5'd3;
	localparam logic [4:0] OP_ADD = 5'd4;
	localparam logic [4:0] OP_ADC = 5'd5;
	localparam logic [4:0] OP_SBC = 5'd6;
	localparam logic [4:0] OP_RSC = 5'd7;
	localparam logic [4:0] OP_TST = 5'd8;
	localparam logic [4:0] OP_TEQ = 5'd9;
	localparam logic [4:0] OP_CMP = 5'd10;
	localparam logic [4:0] OP_CMN = 5'd11;
	localparam logic [4:0] OP_ORR = 5'd12;
	localparam logic [4:0] OP_MOV = 5'd13;
	localparam logic [4:0] OP_BIC = 5'd14;
	localparam logic [4:0] OP_MVN = 5'd15;
	localparam logic [4:0] OP_MUL = 5'd16;
	localparam logic [4:0] OP_MLA = 5'd17;

	// Condition codes
	localparam logic [3:0] COND_EQ = 4'd0;
	localparam logic [3:0] COND_NE = 4'd1;
	localparam logic [3:0] COND_CS = 4'd2;
	localparam logic [3:0] COND_CC = 4'd3;
	localparam logic [3:0] COND_MI = 4'd4;
	localparam logic [3:0] COND_PL = 4'd5;
	localparam logic [3:0] COND_VS = 4'd6;
	localparam logic [3:0] COND_VC = 4'd7;
	localparam logic [3:0] COND_HI = 4'd8;
	localparam logic [3:0] COND_LS = 4'd9;
	localparam logic [3:0] COND_GE = 4'd10;
	localparam logic [3:0] COND_LT = 4'd11;
	localparam logic [3:0] COND_GT = 4'd12;
	localparam logic [3:0] COND_LE = 4'd13;
	localparam logic [3:0] COND_AL = 4'd14;
	localparam logic [3:0] COND_NV = 4'd15;

	// Second operand modes
	localparam logic [1:0] MODE_IMM     = 2'd0;
	localparam logic [1:0] MODE_REG_IMM = 2'd1;
	localparam logic [1:0] MODE_REG_REG = 2'd2;

	// Shift kinds
	localparam logic [1:0] SK_LSL = 2'd0;
	localparam logic [1:0] SK_LSR = 2'd1;
	localparam logic [1:0] SK_ASR = 2'd2;
	localparam logic [1:0] SK_ROR = 2'd3;

	localparam int unsigned WORD_BITS = 32;

	typedef struct packed {
		logic [4:0]  op;
		logic [3:0]  cond;
		logic        set_flags;
		logic [1:0]  op2_mode;
		logic [31:0] operand_n;
		logic [31:0] operand_m;
		logic [31:0] operand_s;
		logic [31:0] immediate;
		logic [1:0]  shift_kind;
		logic [4:0]  imm_shamt;
	} req_t;

	typedef struct packed {
		logic        executed;
		logic        write_result;
		logic [31:0] result;
		logic        flag_n;
		logic        flag_z;
		logic        flag_c;
		logic        flag_v;
	} rsp_t;

	typedef struct packed {
		logic n;
		logic z;
		logic c;
		logic v;
	} flags_t;

endpackage

[hdl/cawf_shifter.sv]
// Barrel shifter that forms the second operand and the shifter carry.
module cawf_shifter import cawf_pkg::*; (
	input  logic [1:0]  op2_mode,
	input  logic [1:0]  shift_kind,
	input  logic [4:0]  imm_shamt,
	input  logic [31:0] operand_m,
	input  logic [31:0] operand_s,
	input  logic [31:0] immediate,
	input  logic        carry_in,
	output logic [31:0] op2,
	output logic        carry_out
);

	logic [7:0]  reg_amt;
	logic [4:0]  amt;
	logic [63:0] lsl_w;
	logic [63:0] lsr_w;
	logic [63:0] asr_w;
	logic [63:0] ror_w;
	logic [31:0] small_val;
	logic        small_co;
	logic [31:0] sign_fill;

	assign reg_amt   = operand_s[7:0];
	assign amt       = (op2_mode == MODE_REG_IMM) ? imm_shamt : reg_amt[4:0];
	assign sign_fill = {WORD_BITS{operand_m[31]}};

	// Shift by an amount of 1..31; the carry is the last bit shifted out
	always_comb begin
		lsl_w = {32'd0, operand_m} << amt;
		lsr_w = {operand_m, 32'd0} >> amt;
		asr_w = 64'($signed({operand_m, 32'd0}) >>> amt);
		ror_w = {operand_m, operand_m} >> amt;
		unique case (shift_kind)
			SK_LSL: begin
				small_val = lsl_w[31:0];
				small_co  = lsl_w[32];
			end
			SK_LSR: begin
				small_val = lsr_w[63:32];
				small_co  = lsr_w[31];
			end
			SK_ASR: begin
				small_val = asr_w[63:32];
				small_co  = asr_w[31];
			end
			default: begin
				small_val = ror_w[31:0];
				small_co  = ror_w[31];
			end
		endcase
	end

	// Pick the operand, handling zero and out-of-range amounts
	always_comb begin
		op2       = operand_m;
		carry_out = carry_in;
		if (op2_mode == MODE_IMM) begin
			op2 = immediate;
		end else if (op2_mode == MODE_REG_IMM) begin
			if (imm_shamt != 5'd0) begin
				op2       = small_val;
				carry_out = small_co;
			end else begin
				unique case (shift_kind)
					SK_LSL: begin
						op2 = operand_m;
					end
					SK_LSR: begin
						op2       = 32'd0;
						carry_out = operand_m[31];
					end
					SK_ASR: begin
						op2       = sign_fill;
						carry_out = operand_m[31];
					end
					default: begin
						// rotate right extended through carry
						op2       = {carry_in, operand_m[31:1]};
						carry_out = operand_m[0];
					end
				endcase
			end
		end else begin
			if (reg_amt == 8'd0) begin
				op2 = operand_m;
			end else if (reg_amt < 8'(WORD_BITS)) begin
				op2       = small_val;
				carry_out = small_co;
			end else begin
				unique case (shift_kind)
					SK_LSL: begin
						op2       = 32'd0;
						carry_out = (reg_amt == 8'(WORD_BITS)) ? operand_m[0] : 1'b0;
					end
					SK_LSR: begin
						op2       = 32'd0;
						carry_out = (reg_amt == 8'(WORD_BITS)) ? operand_m[31] : 1'b0;
					end
					SK_ASR: begin
						op2       = sign_fill;
						carry_out = operand_m[31];
					end
					default: begin
						if (reg_amt[4:0] == 5'd0) begin
							op2       = operand_m;
							carry_out = operand_m[31];
						end else begin
							op2       = small_val;
							carry_out = small_co;
						end
					end
				endcase
			end
		end
	end

endmodule

[hdl/cawf_exec.sv]
// Condition check, ALU, multiplier and flag update for one instruction.
module cawf_exec import cawf_pkg::*; (
	input  req_t   req,
	input  flags_t flags,
	output rsp_t   rsp
);

	logic [31:0] op2;
	logic        sh_co;
	logic        cond_ok;
	logic        op_ok;
	logic        is_test;
	logic        is_mul;
	logic [31:0] add_a;
	logic [31:0] add_b;
	logic        add_cin;
	logic [32:0] sum;
	logic        add_v;
	logic        arith;
	logic [31:0] prod;
	logic [31:0] res;
	logic        nc;
	logic        nv;
	logic        upd;

	cawf_shifter u_shifter (
		.op2_mode   (req.op2_mode),
		.shift_kind (req.shift_kind),
		.imm_shamt  (req.imm_shamt),
		.operand_m  (req.operand_m),
		.operand_s  (req.operand_s),
		.immediate  (req.immediate),
		.carry_in   (flags.c),
		.op2        (op2),
		.carry_out  (sh_co)
	);

	// Evaluate the condition against the held flags
	always_comb begin
		unique case (req.cond)
			COND_EQ: cond_ok = flags.z;
			COND_NE: cond_ok = !flags.z;
			COND_CS: cond_ok = flags.c;
			COND_CC: cond_ok = !flags.c;
			COND_MI: cond_ok = flags.n;
			COND_PL: cond_ok = !flags.n;
			COND_VS: cond_ok = flags.v;
			COND_VC: cond_ok = !flags.v;
			COND_HI: cond_ok = flags.c && !flags.z;
			COND_LS: cond_ok = !flags.c || flags.z;
			COND_GE: cond_ok = (flags.n == flags.v);
			COND_LT: cond_ok = (flags.n != flags.v);
			COND_GT: cond_ok = !flags.z && (flags.n == flags.v);
			COND_LE: cond_ok = flags.z || (flags.n != flags.v);
			COND_AL: cond_ok = 1'b1;
			COND_NV: cond_ok = 1'b0;
			default: cond_ok = 1'b0;
		endcase
	end

	assign op_ok   = (req.op <= OP_MLA);
	assign is_test = (req.op >= OP_TST) && (req.op <= OP_CMN);
	assign is_mul  = (req.op == OP_MUL) || (req.op == OP_MLA);

	// Steer the shared adder; subtraction uses the inverted operand
	always_comb begin
		add_a   = req.operand_n;
		add_b   = op2;
		add_cin = 1'b0;
		arith   = 1'b1;
		unique case (req.op)
			OP_SUB, OP_CMP: begin
				add_b   = ~op2;
				add_cin = 1'b1;
			end
			OP_RSB: begin
				add_a   = op2;
				add_b   = ~req.operand_n;
				add_cin = 1'b1;
			end
			OP_ADD, OP_CMN: begin
				add_cin = 1'b0;
			end
			OP_ADC: begin
				add_cin = flags.c;
			end
			OP_SBC: begin
				add_b   = ~op2;
				add_cin = flags.c;
			end
			OP_RSC: begin
				add_a   = op2;
				add_b   = ~req.operand_n;
				add_cin = flags.c;
			end
			default: begin
				arith = 1'b0;
			end
		endcase
	end

	assign sum   = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_cin};
	assign add_v = (add_a[31] ^ sum[31]) & (add_b[31] ^ sum[31]);
	assign prod  = req.operand_m * req.operand_s;

	// Select the result value
	always_comb begin
		unique case (req.op)
			OP_AND, OP_TST: res = req.operand_n & op2;
			OP_EOR, OP_TEQ: res = req.operand_n ^ op2;
			OP_ORR:         res = req.operand_n | op2;
			OP_MOV:         res = op2;
			OP_BIC:         res = req.operand_n & ~op2;
			OP_MVN:         res = ~op2;
			OP_MUL:         res = prod;
			OP_MLA:         res = prod + req.operand_n;
			default:        res = sum[31:0];
		endcase
	end

	// Logical operations take the shifter carry and keep V
	assign nc  = arith ? sum[32] : sh_co;
	assign nv  = arith ? add_v : flags.v;
	assign upd = is_test || req.set_flags;

	// Assemble the result beat with the flags that hold afterward
	always_comb begin
		rsp.executed     = 1'b0;
		rsp.write_result = 1'b0;
		rsp.result       = 32'd0;
		rsp.flag_n       = flags.n;
		rsp.flag_z       = flags.z;
		rsp.flag_c       = flags.c;
		rsp.flag_v       = flags.v;
		if (op_ok && cond_ok) begin
			rsp.executed     = 1'b1;
			rsp.write_result = !is_test;
			rsp.result       = res;
			if (upd) begin
				rsp.flag_n = res[31];
				rsp.flag_z = (res == 32'd0);
				if (!is_mul) begin
					rsp.flag_c = nc;
					rsp.flag_v = nv;
				end
			end
		end
	end

endmodule

[hdl/conditional_alu_with_flags.sv]
// Top level: input register, execute logic, result register and flag register.
//
// Conditional ALU with flags. Takes one instruction beat per clock cycle while req_stall is low and
// returns each result beat through the input register, then the result register. The N, Z, C and V
// flags update as each beat moves into the result register, so the next instruction sees them
// in the very next cycle with no bubble. The combinational path through the barrel shifter,
// the 33-bit adder and the 32x32 multiplier (with the accumulate add for MLA) sets the clock.
// A result waiting under stall does not block intake: one more beat is held in the input
// register before req_stall rises.
module conditional_alu_with_flags import cawf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	logic   valid_s1;
	req_t   req_s1;
	logic   valid_s2;
	rsp_t   rsp_s2;
	flags_t flags_q;
	rsp_t   exec_rsp;
	logic   s2_free;
	logic   adv_s1;
	logic   accept;

	assign s2_free   = !valid_s2 || !rsp_stall;
	assign adv_s1    = valid_s1 && s2_free;
	assign req_stall = valid_s1 && !s2_free;
	assign accept    = req_valid && !req_stall;

	cawf_exec u_exec (
		.req   (req_s1),
		.flags (flags_q),
		.rsp   (exec_rsp)
	);

	// Advance valid bits and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			flags_q  <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s1) begin
				flags_q <= '{n: exec_rsp.flag_n, z: exec_rsp.flag_z,
				             c: exec_rsp.flag_c, v: exec_rsp.flag_v};
			end
		end
	end

	// Hold payload while stalled
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
		if (adv_s1) begin
			rsp_s2 <= exec_rsp;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

	// A destination write only comes from an executed instruction
	a_write_needs_exec: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (!rsp.write_result || rsp.executed))
		else $error("write_result without executed");

	// A skipped instruction reports a zero result
	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.executed) |-> (rsp.result == 32'd0))
		else $error("nonzero result on skipped instruction");

	// Flags only move when a beat enters the result register
	a_flags_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(flags_q))
		else $error("flags changed without an advancing beat");

	// A skipped instruction leaves the flags untouched
	a_skip_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && !exec_rsp.executed) |=> $stable(flags_q))
		else $error("flags changed on skipped instruction");

	// The flag register tracks the last delivered beat
	a_flags_match: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> (flags_q == {rsp_s2.flag_n, rsp_s2.flag_z, rsp_s2.flag_c, rsp_s2.flag_v}))
		else $error("flag register differs from result beat");

endmodule
